FILE: design/lce_pkg.sv
// Package for the logic change event encoder: widths, constants, codes and
// the structs passed between its modules. Depends on nothing.
`default_nettype none

package lce_pkg;

  // Channel layout and lane split.
  localparam int CHANNELS   = 64;
  localparam int LANE_W     = 8;
  localparam int LANES      = (CHANNELS + LANE_W - 1) / LANE_W;
  localparam int PEND_W     = LANES * LANE_W;
  localparam int LANE_IDX_W = $clog2(LANE_W);
  localparam int CH_W       = 6;
  localparam int LANE_SEL_W = CH_W - LANE_IDX_W;
  localparam int SAMPLE_W   = 64;
  localparam int NCH_W      = 7;

  // Arithmetic widths for the timestamp.
  localparam int COUNT_W  = 48;
  localparam int RATE_W   = 34;
  localparam int TS_W     = 64;
  localparam int PERIOD_W = 30;
  localparam int HALF_W   = COUNT_W / 2;
  localparam int MUL_W    = HALF_W + PERIOD_W;
  localparam int NUM_W    = COUNT_W + PERIOD_W;
  localparam int STEP_W   = $clog2(NUM_W);

  localparam logic [PERIOD_W-1:0] PERIOD_G = PERIOD_W'(1000000000);
  localparam logic [PERIOD_W-1:0] PERIOD_M = PERIOD_W'(1000000);
  localparam logic [PERIOD_W-1:0] PERIOD_K = PERIOD_W'(1000);

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_SAMPLE_RATE   = 1'b0,
    CFG_CHANNEL_COUNT = 1'b1
  } cfg_reg_e;

  // Top-level sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WAIT,
    ST_EMIT
  } enc_state_e;

  // Timestamp unit states.
  typedef enum logic [2:0] {
    TS_IDLE,
    TS_MUL_LO,
    TS_MUL_HI,
    TS_SUM,
    TS_DIV,
    TS_ROUND
  } ts_state_e;

  // What one lane reports about its pending changes.
  typedef struct packed {
    logic                  any;
    logic                  more;
    logic [LANE_IDX_W-1:0] idx;
  } lane_res_t;

  // The channel picked by the merging stage.
  typedef struct packed {
    logic            any;
    logic            last;
    logic [CH_W-1:0] channel;
  } pick_t;

endpackage

`default_nettype wire

FILE: design/lce_if.sv
// Handshake channels of the logic change event encoder: input items, result
// items and configuration writes. Depends on lce_pkg.
`default_nettype none

interface lce_in_if;
  logic                          valid;
  logic                          ready;
  logic                          command;
  logic [lce_pkg::SAMPLE_W-1:0]  sample_bits;

  modport source(output valid, command, sample_bits, input ready);
  modport sink(input valid, command, sample_bits, output ready);
endinterface

interface lce_out_if;
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic [lce_pkg::TS_W-1:0]  timestamp;
  logic [lce_pkg::CH_W-1:0]  channel;
  logic                      level;
  logic                      last;

  modport source(output valid, kind, timestamp, channel, level, last, input ready);
  modport sink(input valid, kind, timestamp, channel, level, last, output ready);
endinterface

interface lce_cfg_if;
  logic                        valid;
  logic                        ready;
  lce_pkg::cfg_reg_e           index;
  logic [lce_pkg::RATE_W-1:0]  data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: design/lce_lane.sv
// One lane: finds the lowest pending channel among its group of channels.
// Depends on lce_pkg.
`default_nettype none

module lce_lane (
  input  wire logic [lce_pkg::LANE_W-1:0] bits_i,
  output lce_pkg::lane_res_t              res_o
);
  import lce_pkg::*;

  logic [LANE_IDX_W-1:0] idx;

  // Priority encode from the top so the lowest set bit wins.
  always_comb begin
    idx = '0;
    for (int b = LANE_W - 1; b >= 0; b--) begin
      if (bits_i[b]) begin
        idx = LANE_IDX_W'(b);
      end
    end
  end

  // More than one bit set means this lane is not done after this pick.
  assign res_o.any  = |bits_i;
  assign res_o.more = |(bits_i & (bits_i - LANE_W'(1)));
  assign res_o.idx  = idx;

endmodule

`default_nettype wire

FILE: design/lce_merge.sv
// Merging stage: picks the lowest lane with a pending change and decides
// whether that event is the last one of the item. Depends on lce_pkg.
`default_nettype none

module lce_merge (
  input  wire lce_pkg::lane_res_t lanes_i [lce_pkg::LANES],
  output lce_pkg::pick_t          pick_o
);
  import lce_pkg::*;

  logic                  found;
  logic                  higher;
  logic [LANE_SEL_W-1:0] sel;
  lane_res_t             win;

  // Lowest active lane wins; any active lane above it means more events.
  always_comb begin
    found  = 1'b0;
    higher = 1'b0;
    sel    = '0;
    win    = '0;
    for (int l = 0; l < LANES; l++) begin
      if (found) begin
        higher = higher | lanes_i[l].any;
      end else if (lanes_i[l].any) begin
        found = 1'b1;
        sel   = LANE_SEL_W'(l);
        win   = lanes_i[l];
      end
    end
  end

  assign pick_o.any     = found;
  assign pick_o.last    = !win.more && !higher;
  assign pick_o.channel = {sel, win.idx};

endmodule

`default_nettype wire

FILE: design/lce_timestamp.sv
// Timestamp unit: round(count * period / rate), ties to even, all ones for a
// zero rate. Two 24x30 partial products, then a bit-serial restoring divider.
// Depends on lce_pkg.
`default_nettype none

module lce_timestamp (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [lce_pkg::COUNT_W-1:0]  count_i,
  input  wire logic [lce_pkg::RATE_W-1:0]   rate_i,
  output logic                              done_o,
  output logic      [lce_pkg::TS_W-1:0]     ts_o
);
  import lce_pkg::*;

  ts_state_e             state_q, state_d;
  logic [COUNT_W-1:0]    count_q;
  logic [PERIOD_W-1:0]   period_q;
  logic [PERIOD_W-1:0]   period_sel;
  logic                  zero_q;
  logic [MUL_W-1:0]      plo_q, phi_q;
  logic [NUM_W-1:0]      num_q;
  logic [RATE_W-1:0]     rem_q;
  logic [TS_W-1:0]       quo_q;
  logic [STEP_W-1:0]     step_q;
  logic [TS_W-1:0]       ts_q;
  logic                  done_q;
  logic [HALF_W-1:0]     mul_a;
  logic [MUL_W-1:0]      prod;
  logic [RATE_W:0]       rem_sh;
  logic                  ge;
  logic [RATE_W:0]       rem_sub;
  logic [RATE_W:0]       twice;
  logic                  round_up;

  // Timescale period chosen by rate thresholds.
  always_comb begin
    if (rate_i > RATE_W'(PERIOD_M)) begin
      period_sel = PERIOD_G;
    end else if (rate_i > RATE_W'(PERIOD_K)) begin
      period_sel = PERIOD_M;
    end else begin
      period_sel = PERIOD_K;
    end
  end

  // One shared multiplier, low half of the count first.
  assign mul_a = (state_q == TS_MUL_HI) ? count_q[COUNT_W-1:HALF_W] : count_q[HALF_W-1:0];
  assign prod  = MUL_W'(mul_a) * MUL_W'(period_q);

  // One restoring division step.
  assign rem_sh  = {rem_q, num_q[NUM_W-1]};
  assign ge      = rem_sh >= {1'b0, rate_i};
  assign rem_sub = rem_sh - {1'b0, rate_i};

  // Round half to even on the final remainder.
  assign twice    = {rem_q, 1'b0};
  assign round_up = (twice > {1'b0, rate_i}) || ((twice == {1'b0, rate_i}) && quo_q[0]);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      TS_IDLE: begin
        if (start_i) begin
          state_d = (rate_i == '0) ? TS_ROUND : TS_MUL_LO;
        end
      end
      TS_MUL_LO: state_d = TS_MUL_HI;
      TS_MUL_HI: state_d = TS_SUM;
      TS_SUM:    state_d = TS_DIV;
      TS_DIV: begin
        if (step_q == '0) begin
          state_d = TS_ROUND;
        end
      end
      TS_ROUND:  state_d = TS_IDLE;
      default:   state_d = TS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= TS_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == TS_ROUND);
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      TS_IDLE: begin
        if (start_i) begin
          count_q  <= count_i;
          period_q <= period_sel;
          zero_q   <= (rate_i == '0);
        end
      end
      TS_MUL_LO: plo_q <= prod;
      TS_MUL_HI: phi_q <= prod;
      TS_SUM: begin
        num_q  <= {phi_q, HALF_W'(0)} + NUM_W'(plo_q);
        rem_q  <= '0;
        quo_q  <= '0;
        step_q <= STEP_W'(NUM_W - 1);
      end
      TS_DIV: begin
        rem_q  <= ge ? rem_sub[RATE_W-1:0] : rem_sh[RATE_W-1:0];
        quo_q  <= {quo_q[TS_W-2:0], ge};
        num_q  <= {num_q[NUM_W-2:0], 1'b0};
        step_q <= step_q - STEP_W'(1);
      end
      TS_ROUND: begin
        ts_q <= zero_q ? '1 : quo_q + TS_W'(round_up);
      end
      default: begin
      end
    endcase
  end

  assign done_o = done_q;
  assign ts_o   = ts_q;

endmodule

`default_nettype wire

FILE: design/logic_change_event_encoder_unit.sv
// Top level of the logic change event encoder: sample compare, lanes, merge,
// timestamp unit and output register. Depends on lce_pkg, lce_if, lce_lane,
// lce_merge and lce_timestamp.
//
//  port    dir  carries
//  in_i    in   command, sample_bits
//  out_o   out  kind, timestamp, channel, level, last
//  cfg_i   in   index (sample_rate, channel_count), data
//
// A sample with no change on the enabled channels leaves the block idle.
// A changed sample or an end command waits for the timestamp (low and high
// partial products, a sum, 78 steps of the bit-serial divider in
// lce_timestamp, rounding), then gives one event per cycle unless the output
// stalls; a zero rate skips the arithmetic. Reset is asynchronous and needs
// no clearing pass. A stalled output holds the event in the output register;
// the next input item is accepted once the last event of the item sits there.
`default_nettype none

module logic_change_event_encoder_unit (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  lce_in_if.sink     in_i,
  lce_out_if.source  out_o,
  lce_cfg_if.sink    cfg_i
);
  import lce_pkg::*;

  enc_state_e          state_q, state_d;
  logic [RATE_W-1:0]   rate_q;
  logic [NCH_W-1:0]    chan_count_q;
  logic [SAMPLE_W-1:0] prev_q;
  logic [COUNT_W-1:0]  count_q;
  logic [PEND_W-1:0]   pending_q, pending_d;
  logic                kind_q;
  logic                out_valid_q;
  logic                out_kind_q;
  logic [TS_W-1:0]     out_ts_q;
  logic [CH_W-1:0]     out_ch_q;
  logic                out_lvl_q;
  logic                out_last_q;

  logic                in_fire;
  logic                ts_start;
  logic                ts_done;
  logic [TS_W-1:0]     ts_val;
  logic                emit_load;
  logic [NCH_W-1:0]    n_eff;
  logic [PEND_W-1:0]   diff;
  lane_res_t           lane_res [LANES];
  pick_t               pick;

  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_fire     = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q       <= '0;
      chan_count_q <= NCH_W'(64);
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_SAMPLE_RATE:   rate_q       <= cfg_i.data;
        CFG_CHANNEL_COUNT: chan_count_q <= cfg_i.data[NCH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Changed channels, limited to the enabled ones; all of them at count zero.
  assign n_eff = (chan_count_q > NCH_W'(CHANNELS)) ? NCH_W'(CHANNELS) : chan_count_q;

  always_comb begin
    for (int p = 0; p < PEND_W; p++) begin
      diff[p] = (NCH_W'(p) < n_eff)
                && ((count_q == '0) || (in_i.sample_bits[p] ^ prev_q[p]));
    end
  end

  // Lanes scan their group of pending channels side by side.
  for (genvar l = 0; l < LANES; l++) begin : g_lane
    lce_lane u_lane (
      .bits_i (pending_q[l*LANE_W +: LANE_W]),
      .res_o  (lane_res[l])
    );
  end

  lce_merge u_merge (
    .lanes_i (lane_res),
    .pick_o  (pick)
  );

  lce_timestamp u_timestamp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ts_start),
    .count_i (count_q),
    .rate_i  (rate_q),
    .done_o  (ts_done),
    .ts_o    (ts_val)
  );

  // Next state and control.
  always_comb begin
    state_d   = state_q;
    ts_start  = 1'b0;
    emit_load = (state_q == ST_EMIT) && (!out_valid_q || out_o.ready);
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          ts_start = in_i.command || (diff != '0);
          if (ts_start) begin
            state_d = ST_WAIT;
          end
        end
      end
      ST_WAIT: begin
        if (ts_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_load && (kind_q || pick.last)) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Clear the channel that is being sent.
  always_comb begin
    for (int p = 0; p < PEND_W; p++) begin
      pending_d[p] = pending_q[p]
                     && !(emit_load && !kind_q && (CH_W'(p) == pick.channel));
    end
  end

  // Control and sample state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      prev_q      <= '0;
      count_q     <= '0;
      pending_q   <= '0;
      kind_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_fire) begin
        kind_q <= in_i.command;
        if (!in_i.command) begin
          prev_q    <= in_i.sample_bits;
          count_q   <= count_q + COUNT_W'(1);
          pending_q <= diff;
        end
      end else begin
        pending_q <= pending_d;
      end
      if (emit_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (emit_load) begin
      out_kind_q <= kind_q;
      out_ts_q   <= ts_val;
      out_ch_q   <= kind_q ? '0 : pick.channel;
      out_lvl_q  <= kind_q ? 1'b0 : prev_q[pick.channel];
      out_last_q <= kind_q || pick.last;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.kind      = out_kind_q;
  assign out_o.timestamp = out_ts_q;
  assign out_o.channel   = out_ch_q;
  assign out_o.level     = out_lvl_q;
  assign out_o.last      = out_last_q;

endmodule

`default_nettype wire

FILE: sim/tb.sv
// Self-checking testbench for logic_change_event_encoder_unit: drives sample items, predicts
// change events and final timestamps, and compares every result item field by field.
// Depends on lce_pkg, lce_if and the design files.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lce_pkg::*;

  localparam logic CMD_SAMPLE  = 1'b0;
  localparam logic CMD_END     = 1'b1;
  localparam logic KIND_CHANGE = 1'b0;
  localparam logic KIND_END    = 1'b1;

  localparam int QUIET_LIMIT  = 5000;
  localparam int SETTLE_CYCLES = 100;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS   = 30;

  localparam logic [RATE_W-1:0] RATE_STEPS [7] = '{
    34'd1000, 34'd1001, 34'd1000000, 34'd1000001, 34'd3, 34'd48000, 34'h3_FFFF_FFFF
  };

  typedef struct packed {
    logic                command;
    logic [SAMPLE_W-1:0] bits;
  } sample_item_t;

  typedef struct packed {
    logic            kind;
    logic [TS_W-1:0] stamp;
    logic [CH_W-1:0] channel;
    logic            level;
    logic            last;
  } change_rec_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  lce_in_if  in_bus();
  lce_out_if out_bus();
  lce_cfg_if cfg_bus();

  logic_change_event_encoder_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus),
    .cfg_i  (cfg_bus)
  );

  always #10 clk_i = ~clk_i;

  // Stimulus and expectation stores.
  sample_item_t sample_queue[$];
  change_rec_t  expected_events[$];
  int           queued_items = 0;
  int           fault_count  = 0;
  int           in_idle_max  = 0;
  int           out_idle_max = 0;
  int           send_hold    = 0;
  int           take_hold    = 0;
  int           quiet_cycles = 0;

  // Predictor copy of the configuration and state.
  logic [RATE_W-1:0]   rate_q     = '0;
  logic [NCH_W-1:0]    nch_q      = NCH_W'(64);
  logic [SAMPLE_W-1:0] prev_q     = '0;
  logic [COUNT_W-1:0]  seen_count = '0;

  // Last sample word queued, used to build small changes.
  logic [SAMPLE_W-1:0] gen_prev = '0;

  // Rounded time of a sample count, ties to even; all ones for a zero rate.
  function automatic logic [TS_W-1:0] scaled_time(input logic [COUNT_W-1:0] cnt,
                                                   input logic [RATE_W-1:0] rate);
    logic [PERIOD_W-1:0] unit;
    logic [127:0]        num;
    logic [127:0]        quo;
    logic [127:0]        rem;
    if (rate == '0) return '1;
    if (rate > RATE_W'(PERIOD_M)) unit = PERIOD_G;
    else if (rate > RATE_W'(PERIOD_K)) unit = PERIOD_M;
    else unit = PERIOD_K;
    num = 128'(cnt) * 128'(unit);
    quo = num / 128'(rate);
    rem = num % 128'(rate);
    if (2 * rem > 128'(rate) || (2 * rem == 128'(rate) && quo[0])) quo = quo + 1;
    return quo[TS_W-1:0];
  endfunction

  // Work out the result items of one accepted item and advance the state.
  function automatic void predict_item(input logic cmd, input logic [SAMPLE_W-1:0] bits);
    logic [TS_W-1:0]     stamp;
    logic [SAMPLE_W-1:0] changed;
    int                  span;
    int                  top;
    stamp = scaled_time(seen_count, rate_q);
    if (cmd == CMD_END) begin
      expected_events.push_back('{KIND_END, stamp, CH_W'(0), 1'b0, 1'b1});
      return;
    end
    span = (nch_q > NCH_W'(CHANNELS)) ? CHANNELS : int'(nch_q);
    changed = bits ^ prev_q;
    // The first sample after reset reports every enabled channel.
    if (seen_count == '0) changed = '1;
    top = -1;
    for (int p = 0; p < span; p++) if (changed[p]) top = p;
    for (int p = 0; p < span; p++) begin
      if (changed[p]) begin
        expected_events.push_back('{KIND_CHANGE, stamp, CH_W'(p), bits[p], p == top});
      end
    end
    seen_count = seen_count + 1'b1;
    prev_q = bits;
  endfunction

  function automatic void check_field(input string name, input logic [TS_W-1:0] want,
                                      input logic [TS_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fault_count++;
    end
  endfunction

  function automatic void add_item(input logic cmd, input logic [SAMPLE_W-1:0] bits);
    sample_queue.push_back('{cmd, bits});
    queued_items++;
    if (cmd == CMD_SAMPLE) gen_prev = bits;
  endfunction

  // Mostly small changes on the enabled channels, some repeats, end commands and noise.
  function automatic void add_random_item();
    logic [SAMPLE_W-1:0] word;
    int                  pick;
    int                  span;
    int                  pos;
    pick = $urandom_range(0, 99);
    word = gen_prev;
    span = (nch_q > NCH_W'(CHANNELS)) ? CHANNELS : int'(nch_q);
    if (pick < 8) begin
      add_item(CMD_END, {$urandom, $urandom});
      return;
    end
    if (pick >= 30 && pick < 70) begin
      repeat ($urandom_range(1, 3)) begin
        if (span > 0 && $urandom_range(0, 3) != 0) pos = $urandom_range(0, span - 1);
        else pos = $urandom_range(0, SAMPLE_W - 1);
        word[pos] = ~word[pos];
      end
    end else if (pick >= 70 && pick < 88) begin
      word[7:0] = word[7:0] ^ 8'($urandom_range(1, 255));
    end else if (pick >= 88) begin
      word = {$urandom, $urandom};
    end
    add_item(CMD_SAMPLE, word);
  endfunction

  function automatic logic [NCH_W-1:0] pick_channel_count();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) return NCH_W'(64);
    if (pick < 70) return NCH_W'($urandom_range(2, 63));
    if (pick < 85) return NCH_W'($urandom_range(65, 127));
    if (pick < 90) return NCH_W'(0);
    return NCH_W'(1);
  endfunction

  // Register write over the configuration channel; only called while the block is idle.
  task automatic write_reg(input cfg_reg_e idx, input logic [RATE_W-1:0] value);
    @(posedge clk_i);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk_i); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    if (idx == CFG_SAMPLE_RATE) rate_q = value;
    else nch_q = value[NCH_W-1:0];
  endtask

  // The upper data bits are don't-care for the channel count, so they carry noise.
  task automatic set_config(input logic [RATE_W-1:0] rate, input logic [NCH_W-1:0] nch);
    logic [RATE_W-1:0] word;
    word = {2'($urandom_range(0, 3)), $urandom};
    word[NCH_W-1:0] = nch;
    write_reg(CFG_SAMPLE_RATE, rate);
    write_reg(CFG_CHANNEL_COUNT, word);
  endtask

  // Wait until every item is taken and every event has arrived, then pause
  // with no traffic before the next step.
  task automatic wait_quiet();
    while (queued_items != 0 || expected_events.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Sample item driver; predicts the results of each accepted item.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_bus.valid       <= 1'b0;
      in_bus.command     <= CMD_SAMPLE;
      in_bus.sample_bits <= '0;
      send_hold = 0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        predict_item(in_bus.command, in_bus.sample_bits);
        queued_items--;
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (send_hold != 0) begin
          send_hold = send_hold - 1;
          in_bus.valid <= 1'b0;
        end else if (sample_queue.size() != 0) begin
          in_bus.valid       <= 1'b1;
          in_bus.command     <= sample_queue[0].command;
          in_bus.sample_bits <= sample_queue[0].bits;
          void'(sample_queue.pop_front());
          send_hold = $urandom_range(0, in_idle_max);
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
      take_hold = 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (expected_events.size() == 0) begin
          $error("unexpected result item: kind %0h channel %0d timestamp %0h",
                 out_bus.kind, out_bus.channel, out_bus.timestamp);
          fault_count++;
        end else begin
          check_field("kind", TS_W'(expected_events[0].kind), TS_W'(out_bus.kind));
          check_field("timestamp", expected_events[0].stamp, out_bus.timestamp);
          check_field("channel", TS_W'(expected_events[0].channel), TS_W'(out_bus.channel));
          check_field("level", TS_W'(expected_events[0].level), TS_W'(out_bus.level));
          check_field("last", TS_W'(expected_events[0].last), TS_W'(out_bus.last));
          void'(expected_events.pop_front());
        end
        take_hold = $urandom_range(0, out_idle_max);
      end else if (take_hold != 0) begin
        take_hold = take_hold - 1;
      end
      out_bus.ready <= (take_hold == 0);
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $error("no handshake for %0d cycles, %0d events outstanding",
               QUIET_LIMIT, expected_events.size());
        $display("== FAIL ==");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    logic [RATE_W-1:0] rate;
    rst_ni              = 1'b0;
    in_bus.valid        = 1'b0;
    in_bus.command      = CMD_SAMPLE;
    in_bus.sample_bits  = '0;
    out_bus.ready       = 1'b0;
    cfg_bus.valid       = 1'b0;
    cfg_bus.index       = CFG_SAMPLE_RATE;
    cfg_bus.data        = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset configuration: zero rate saturates every timestamp, all 64 channels enabled.
    add_item(CMD_SAMPLE, '0);
    add_item(CMD_SAMPLE, '1);
    add_item(CMD_SAMPLE, '1);
    add_item(CMD_END, '1);
    add_item(CMD_SAMPLE, 64'h8000_0000_0000_0001);
    wait_quiet();

    // Rate 16 gives exact ties on odd counts; an oversized channel count saturates.
    set_config(34'd16, NCH_W'(127));
    in_idle_max  = 7;
    out_idle_max = 7;
    add_item(CMD_SAMPLE, 64'h5555_5555_5555_5555);
    add_item(CMD_SAMPLE, 64'hAAAA_AAAA_AAAA_AAAA);
    add_item(CMD_END, '0);
    add_item(CMD_END, {$urandom, $urandom});
    add_item(CMD_SAMPLE, 64'hAAAA_AAAA_AAAA_AAAA);
    add_item(CMD_SAMPLE, 64'h2AAA_AAAA_AAAA_AAAA);
    wait_quiet();

    // Largest rate with no channel enabled: samples count but give no event.
    set_config(34'h3_FFFF_FFFF, NCH_W'(0));
    in_idle_max  = 3;
    out_idle_max = 0;
    add_item(CMD_SAMPLE, {$urandom, $urandom});
    add_item(CMD_SAMPLE, ~gen_prev);
    add_item(CMD_END, '0);
    wait_quiet();

    // Smallest rate, one channel: a change on a disabled channel stays silent.
    set_config(34'd1, NCH_W'(1));
    in_idle_max  = 0;
    out_idle_max = 7;
    add_item(CMD_SAMPLE, '0);
    add_item(CMD_SAMPLE, 64'h2);
    add_item(CMD_SAMPLE, 64'h3);
    add_item(CMD_END, '1);
    wait_quiet();

    // Rate of 10000000000 with all 64 channels enabled.
    set_config(34'd10000000000, NCH_W'(64));
    add_item(CMD_SAMPLE, {$urandom, $urandom});
    add_item(CMD_SAMPLE, gen_prev ^ 64'h1_0000_0000);
    add_item(CMD_END, '0);
    wait_quiet();

    // Random phases: a fixed list of rates (the thresholds among them) first, then arbitrary ones.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph < 7) rate = RATE_STEPS[ph];
      else if ($urandom_range(0, 1) == 0) rate = {2'($urandom_range(0, 3)), $urandom};
      else rate = RATE_W'($urandom_range(1, 20000000));
      set_config(rate, pick_channel_count());
      in_idle_max  = ($urandom_range(0, 2) == 0) ? 0 : 7;
      out_idle_max = ($urandom_range(0, 2) == 0) ? 0 : 7;
      repeat (PHASE_ITEMS) add_random_item();
      wait_quiet();
    end

    if (fault_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: logic_change_event_encoder_unit.f
design/lce_pkg.sv
design/lce_if.sv
design/lce_lane.sv
design/lce_merge.sv
design/lce_timestamp.sv
design/logic_change_event_encoder_unit.sv
sim/tb.sv
